[design/sca_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sca_pkg
// Shared constants and helpers for the screen code to ANSI converter: escape
// bytes, emit step positions and the screen code to character mapping.
// ----------------------------------------------------------------------------
package sca_pkg;

    localparam int BYTE_W = 8;
    localparam int STEP_W = 4;

    localparam logic [BYTE_W-1:0] ESC_BYTE     = 8'h1B;
    localparam logic [BYTE_W-1:0] LBRACKET     = 8'h5B;
    localparam logic [BYTE_W-1:0] DIGIT_SEVEN  = 8'h37;
    localparam logic [BYTE_W-1:0] DIGIT_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] LETTER_M     = 8'h6D;
    localparam logic [BYTE_W-1:0] CR_BYTE      = 8'h0D;
    localparam logic [BYTE_W-1:0] LF_BYTE      = 8'h0A;
    localparam logic [BYTE_W-1:0] SPACE_BYTE   = 8'h20;
    localparam logic [BYTE_W-1:0] AT_BYTE      = 8'h40;
    localparam logic [BYTE_W-1:0] TILDE_BYTE   = 8'h7E;
    localparam logic [BYTE_W-1:0] INV_LIMIT    = 8'h40;
    localparam logic [BYTE_W-1:0] CTRL_LIMIT   = 8'h20;
    localparam logic [BYTE_W-1:0] ASCII_MASK   = 8'h7F;

    // fixed emit schedule: mode escape, character, closing escape, cr lf
    localparam logic [STEP_W-1:0] STEP_MODE_ESC = 4'd0;
    localparam logic [STEP_W-1:0] STEP_MODE_BRK = 4'd1;
    localparam logic [STEP_W-1:0] STEP_MODE_DIG = 4'd2;
    localparam logic [STEP_W-1:0] STEP_MODE_M   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_CHAR     = 4'd4;
    localparam logic [STEP_W-1:0] STEP_CLS_ESC  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_CLS_BRK  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_CLS_DIG  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_CLS_M    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_CR       = 4'd9;
    localparam logic [STEP_W-1:0] STEP_LF       = 4'd10;

    function automatic logic [BYTE_W-1:0] map_char(input logic [BYTE_W-1:0] code);
        logic [BYTE_W-1:0] ch;
        if (code < CTRL_LIMIT)
            ch = AT_BYTE + code;
        else if (code < INV_LIMIT)
            ch = code;
        else
            ch = code & ASCII_MASK;
        if (ch < SPACE_BYTE || ch > TILDE_BYTE)
            ch = SPACE_BYTE;
        return ch;
    endfunction

endpackage

[design/screen_code_to_ansi_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// screen_code_to_ansi_top
// Converts text-screen codes into an ANSI terminal byte stream, inserting
// video mode escapes on inverse changes, and a normal-video escape after inverse text plus cr lf at row ends.
// ----------------------------------------------------------------------------
//  channel   | signals                              | role
//  ----------+--------------------------------------+-----------------------
//  input     | in_valid, in_ready, screen_code,     | one screen code per
//            | row_last                             | transaction
//  output    | out_valid, out_ready, out_byte,      | one terminal byte per
//            | out_last                             | transaction
//
//  one output byte per cycle unless the output stalls: a plain character
//  emits its byte alone, a mode change puts the mode escape before it and
//  a row end adds a closing escape after inverse text, then cr lf
//  the next item is taken in the cycle its previous item's final byte moves
//  to the output register: unstalled plain characters stream one per cycle
//  reset returns to normal video with both registers empty
//  a stalled output holds its byte and stalls the emitter and input
// ----------------------------------------------------------------------------
module screen_code_to_ansi_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [sca_pkg::BYTE_W-1:0]  screen_code,
    input  logic                        row_last,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [sca_pkg::BYTE_W-1:0]  out_byte,
    output logic                        out_last
);
    import sca_pkg::*;

    logic              item_valid_reg, item_valid_next;
    logic [BYTE_W-1:0] item_code_reg;
    logic              item_last_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              inverse_reg, inverse_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;

    logic              in_accept;
    logic              advance;
    logic              code_inverse;
    logic              mode_change;
    logic              close_inv;
    logic [BYTE_W-1:0] ch;
    logic [STEP_W-1:0] cur_step;
    logic [STEP_W-1:0] following_step;
    logic              final_step;
    logic [BYTE_W-1:0] emit_byte;

    assign code_inverse = item_code_reg < INV_LIMIT;
    assign mode_change  = code_inverse != inverse_reg;
    assign close_inv    = item_last_reg && code_inverse;
    assign ch           = map_char(item_code_reg);

    // skip the mode escape when the video mode already matches
    assign cur_step = (step_reg == STEP_MODE_ESC && !mode_change) ? STEP_CHAR : step_reg;

    always_comb
    begin
        final_step     = 1'b0;
        following_step = cur_step + 4'd1;
        case (cur_step)
            STEP_CHAR:
            begin
                if (!item_last_reg)
                    final_step = 1'b1;
                else if (close_inv)
                    following_step = STEP_CLS_ESC;
                else
                    following_step = STEP_CR;
            end
            STEP_LF:
            begin
                final_step = 1'b1;
            end
            default:
            begin
                following_step = cur_step + 4'd1;
            end
        endcase
    end

    always_comb
    begin
        case (cur_step)
            STEP_MODE_ESC: emit_byte = ESC_BYTE;
            STEP_MODE_BRK: emit_byte = LBRACKET;
            STEP_MODE_DIG: emit_byte = code_inverse ? DIGIT_SEVEN : DIGIT_ZERO;
            STEP_MODE_M:   emit_byte = LETTER_M;
            STEP_CHAR:     emit_byte = ch;
            STEP_CLS_ESC:  emit_byte = ESC_BYTE;
            STEP_CLS_BRK:  emit_byte = LBRACKET;
            STEP_CLS_DIG:  emit_byte = DIGIT_ZERO;
            STEP_CLS_M:    emit_byte = LETTER_M;
            STEP_CR:       emit_byte = CR_BYTE;
            STEP_LF:       emit_byte = LF_BYTE;
            default:       emit_byte = SPACE_BYTE;
        endcase
    end

    assign advance   = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || (advance && final_step);
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        step_next       = step_reg;
        inverse_next    = inverse_reg;
        if (advance)
        begin
            if (final_step)
            begin
                item_valid_next = 1'b0;
                step_next       = STEP_MODE_ESC;
                inverse_next    = item_last_reg ? 1'b0 : code_inverse;
            end
            else
            begin
                step_next = following_step;
            end
        end
        if (in_accept)
            item_valid_next = 1'b1;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            step_reg       <= STEP_MODE_ESC;
            inverse_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            step_reg       <= step_next;
            inverse_reg    <= inverse_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_code_reg <= screen_code;
            item_last_reg <= row_last;
        end
        if (advance)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= final_step;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    // row end always leaves normal video behind
    a_row_end_normal: assert property (@(posedge clk) disable iff (!rst_n)
        advance && final_step && item_last_reg |=> !inverse_reg)
        else $error("inverse mode still set after row end");

    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid_reg |-> step_reg == STEP_MODE_ESC)
        else $error("step counter not rewound while empty");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg |-> step_reg <= STEP_LF)
        else $error("step counter beyond line feed");

    a_cr_then_lf: assert property (@(posedge clk) disable iff (!rst_n)
        advance && cur_step == STEP_CR |=> item_valid_reg && step_reg == STEP_LF)
        else $error("carriage return not followed by line feed");

    // the video mode register only moves at the item's final byte
    a_mode_escape_once: assert property (@(posedge clk) disable iff (!rst_n)
        advance && cur_step == STEP_MODE_M |-> mode_change)
        else $error("mode escape sent but video mode unchanged");

endmodule
